### hdl/alarm_clock_controller_unit_assert.svh
// assertion macros shared by the alarm clock controller modules
`ifndef ALARM_CLOCK_CONTROLLER_UNIT_ASSERT_SVH
`define ALARM_CLOCK_CONTROLLER_UNIT_ASSERT_SVH

// condition holds at every clock edge out of reset
`define ACC_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ACC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define ACC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/acc_pkg.sv
// types, constants and dial arithmetic for the alarm clock controller
package acc_pkg;

	localparam int DIAL = 720;
	localparam logic [9:0] HOUR_STEP = 10'd60;
	localparam logic [9:0] MIN_STEP = 10'd12;
	localparam logic [9:0] ONE_STEP = 10'd1;
	localparam logic [7:0] TPM_RESET = 8'd60;

	// reciprocal multipliers, exact for indices below 720
	localparam logic [10:0] RECIP_60 = 11'd1093;
	localparam logic [12:0] RECIP_12 = 13'd5462;
	localparam logic [3:0] NOON_HOUR = 4'd12;

	localparam logic [1:0] MODE_CODE_AMB = 2'd0;
	localparam logic [1:0] MODE_CODE_ALM = 2'd1;
	localparam logic [1:0] MODE_CODE_TIME = 2'd2;
	localparam logic [1:0] STEP_CODE_IDLE = 2'd0;
	localparam logic [1:0] STEP_CODE_HOUR = 2'd1;
	localparam logic [1:0] STEP_CODE_MIN = 2'd2;

	typedef enum logic [2:0] {
		MODE_AMB  = 3'b001,
		MODE_ALM  = 3'b010,
		MODE_TIME = 3'b100
	} mode_t;

	typedef enum logic [2:0] {
		STEP_IDLE = 3'b001,
		STEP_HOUR = 3'b010,
		STEP_MIN  = 3'b100
	} step_t;

	// classified item travelling from front to back
	typedef struct packed {
		logic tick;
		logic st_fall;
		logic sa_fall;
		logic inc;
		logic dec;
		logic amb_fall;
	} cmd_t;

	// one result beat
	typedef struct packed {
		logic       sound;
		logic       ringing;
		logic [9:0] alarm_m;
		logic [9:0] alarm_h;
		logic       alarm_on;
		logic [5:0] disp_m;
		logic [3:0] disp_h;
		logic [9:0] shown_m;
		logic [9:0] shown_h;
		logic [1:0] step;
		logic [1:0] mode;
	} res_t;

	function automatic logic [9:0] dial_add(logic [9:0] v, logic [9:0] d);
		logic [10:0] s;
		s = {1'b0, v} + {1'b0, d};
		if (s >= 11'(DIAL)) begin
			s = s - 11'(DIAL);
		end
		return s[9:0];
	endfunction

	function automatic logic [9:0] dial_sub(logic [9:0] v, logic [9:0] d);
		logic [10:0] s;
		if (v >= d) begin
			s = {1'b0, v} - {1'b0, d};
		end else begin
			s = {1'b0, v} + 11'(DIAL) - {1'b0, d};
		end
		return s[9:0];
	endfunction

endpackage

### hdl/acc_front.sv
// front end: takes input beats, detects button edges and queues commands
module acc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,  // set_time, set_alarm, increment, decrement, ambient
	input  logic              s_tuser,  // op
	input  logic              q_full,
	output logic              push,
	output acc_pkg::cmd_t     cmd
);

	logic [2:0] prev_q;  // set-time, set-alarm, ambient levels
	logic       is_poll;

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;
	assign is_poll  = s_tuser;

	always_comb begin
		cmd.tick     = !is_poll;
		cmd.st_fall  = is_poll && !s_tdata[0] && prev_q[0];
		cmd.sa_fall  = is_poll && !s_tdata[1] && prev_q[1];
		cmd.inc      = is_poll && !s_tdata[2];
		cmd.dec      = is_poll && !s_tdata[3];
		cmd.amb_fall = is_poll && !s_tdata[4] && prev_q[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 3'b111;
		end else if (push && is_poll) begin
			prev_q <= {s_tdata[4], s_tdata[1], s_tdata[0]};
		end
	end

endmodule

### hdl/acc_fifo.sv
// short command queue between front and back
module acc_fifo #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  acc_pkg::cmd_t wr_cmd,
	input  logic          pop,
	output acc_pkg::cmd_t rd_cmd,
	output logic          full,
	output logic          not_empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	acc_pkg::cmd_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rd_cmd    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`include "alarm_clock_controller_unit_assert.svh"

	`ACC_ASSERT_NEXT(a_full_drains_by_pop, full && !pop, full, "full queue lost an entry")

endmodule

### hdl/acc_back.sv
// back end: clock state, setting state machine and result register
module acc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [7:0]    cfg_wdata,
	input  logic          cmd_valid,
	input  acc_pkg::cmd_t cmd,
	output logic          pop,
	output logic          res_valid,
	input  logic          res_ready,
	output acc_pkg::res_t res
);

	acc_pkg::mode_t mode_q, mode_d;
	acc_pkg::step_t step_q, step_d;

	logic [7:0] tpm_q;
	logic [7:0] sec_q, sec_d;
	logic [9:0] cur_h_q, cur_h_d, cur_m_q, cur_m_d;
	logic [9:0] et_h_q, et_h_d, et_m_q, et_m_d;
	logic [9:0] ea_h_q, ea_h_d, ea_m_q, ea_m_d;
	logic [9:0] alm_h_q, alm_h_d, alm_m_q, alm_m_d;
	logic       alm_en_q, alm_en_d, ring_q, ring_d, sound_q, sound_d;

	logic [8:0] sec_inc;
	logic [9:0] eh_cur, em_cur, eh_up, em_up, eh_dn, em_dn;
	logic [9:0] shown_h_d, shown_m_d;

	// result register payload
	logic [1:0] out_mode_q, out_step_q;
	logic [9:0] out_sh_q, out_sm_q, out_ah_q, out_am_q;
	logic       out_en_q, out_ring_q, out_sound_q, res_valid_q;

	logic [20:0] hour_prod;
	logic [22:0] min_prod;

	assign pop       = cmd_valid && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign sec_inc   = {1'b0, sec_q} + 9'd1;

	// edit candidates for the pair selected by the mode
	always_comb begin
		eh_cur = (mode_q == acc_pkg::MODE_ALM) ? ea_h_q : et_h_q;
		em_cur = (mode_q == acc_pkg::MODE_ALM) ? ea_m_q : et_m_q;
		if (step_q == acc_pkg::STEP_HOUR) begin
			eh_up = acc_pkg::dial_add(eh_cur, acc_pkg::HOUR_STEP);
			eh_dn = acc_pkg::dial_sub(eh_cur, acc_pkg::HOUR_STEP);
			em_up = em_cur;
			em_dn = em_cur;
		end else begin
			eh_up = acc_pkg::dial_add(eh_cur, acc_pkg::ONE_STEP);
			eh_dn = acc_pkg::dial_sub(eh_cur, acc_pkg::ONE_STEP);
			em_up = acc_pkg::dial_add(em_cur, acc_pkg::MIN_STEP);
			em_dn = acc_pkg::dial_sub(em_cur, acc_pkg::MIN_STEP);
		end
	end

	always_comb begin
		mode_d   = mode_q;
		step_d   = step_q;
		sec_d    = sec_q;
		cur_h_d  = cur_h_q;
		cur_m_d  = cur_m_q;
		et_h_d   = et_h_q;
		et_m_d   = et_m_q;
		ea_h_d   = ea_h_q;
		ea_m_d   = ea_m_q;
		alm_h_d  = alm_h_q;
		alm_m_d  = alm_m_q;
		alm_en_d = alm_en_q;
		ring_d   = ring_q;
		sound_d  = sound_q;
		if (cmd.tick) begin
			if (sec_inc >= {1'b0, tpm_q}) begin
				sec_d   = '0;
				cur_m_d = acc_pkg::dial_add(cur_m_q, acc_pkg::MIN_STEP);
				cur_h_d = acc_pkg::dial_add(cur_h_q, acc_pkg::ONE_STEP);
				if (alm_en_q && cur_h_d == alm_h_q && cur_m_d == alm_m_q) begin
					ring_d  = 1'b1;
					sound_d = 1'b1;
				end
			end else begin
				sec_d = sec_inc[7:0];
			end
		end else if (cmd.st_fall && mode_q != acc_pkg::MODE_ALM) begin
			mode_d = acc_pkg::MODE_TIME;
			unique case (step_q)
				acc_pkg::STEP_IDLE: step_d = acc_pkg::STEP_HOUR;
				acc_pkg::STEP_HOUR: step_d = acc_pkg::STEP_MIN;
				default: begin
					mode_d  = acc_pkg::MODE_AMB;
					step_d  = acc_pkg::STEP_IDLE;
					cur_h_d = et_h_q;
					cur_m_d = et_m_q;
				end
			endcase
		end else if (cmd.sa_fall && mode_q != acc_pkg::MODE_TIME) begin
			mode_d = acc_pkg::MODE_ALM;
			unique case (step_q)
				acc_pkg::STEP_IDLE: step_d = acc_pkg::STEP_HOUR;
				acc_pkg::STEP_HOUR: step_d = acc_pkg::STEP_MIN;
				default: begin
					mode_d   = acc_pkg::MODE_AMB;
					step_d   = acc_pkg::STEP_IDLE;
					alm_h_d  = ea_h_q;
					alm_m_d  = ea_m_q;
					alm_en_d = 1'b1;
				end
			endcase
		end else if (cmd.inc || cmd.dec) begin
			if (mode_q == acc_pkg::MODE_ALM) begin
				ea_h_d = cmd.inc ? eh_up : eh_dn;
				ea_m_d = cmd.inc ? em_up : em_dn;
			end else if (mode_q == acc_pkg::MODE_TIME) begin
				et_h_d = cmd.inc ? eh_up : eh_dn;
				et_m_d = cmd.inc ? em_up : em_dn;
			end
		end else if (cmd.amb_fall) begin
			mode_d  = acc_pkg::MODE_AMB;
			step_d  = acc_pkg::STEP_IDLE;
			sound_d = 1'b0;
			if (ring_q) begin
				alm_en_d = 1'b0;
				ring_d   = 1'b0;
			end
		end
	end

	always_comb begin
		unique case (mode_d)
			acc_pkg::MODE_ALM: begin
				shown_h_d = ea_h_d;
				shown_m_d = ea_m_d;
			end
			acc_pkg::MODE_TIME: begin
				shown_h_d = et_h_d;
				shown_m_d = et_m_d;
			end
			default: begin
				shown_h_d = cur_h_d;
				shown_m_d = cur_m_d;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpm_q       <= acc_pkg::TPM_RESET;
			mode_q      <= acc_pkg::MODE_AMB;
			step_q      <= acc_pkg::STEP_IDLE;
			sec_q       <= '0;
			cur_h_q     <= '0;
			cur_m_q     <= '0;
			et_h_q      <= '0;
			et_m_q      <= '0;
			ea_h_q      <= '0;
			ea_m_q      <= '0;
			alm_h_q     <= '0;
			alm_m_q     <= '0;
			alm_en_q    <= 1'b0;
			ring_q      <= 1'b0;
			sound_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				tpm_q <= cfg_wdata;
			end
			if (pop) begin
				mode_q   <= mode_d;
				step_q   <= step_d;
				sec_q    <= sec_d;
				cur_h_q  <= cur_h_d;
				cur_m_q  <= cur_m_d;
				et_h_q   <= et_h_d;
				et_m_q   <= et_m_d;
				ea_h_q   <= ea_h_d;
				ea_m_q   <= ea_m_d;
				alm_h_q  <= alm_h_d;
				alm_m_q  <= alm_m_d;
				alm_en_q <= alm_en_d;
				ring_q   <= ring_d;
				sound_q  <= sound_d;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			unique case (mode_d)
				acc_pkg::MODE_ALM:  out_mode_q <= acc_pkg::MODE_CODE_ALM;
				acc_pkg::MODE_TIME: out_mode_q <= acc_pkg::MODE_CODE_TIME;
				default:            out_mode_q <= acc_pkg::MODE_CODE_AMB;
			endcase
			unique case (step_d)
				acc_pkg::STEP_HOUR: out_step_q <= acc_pkg::STEP_CODE_HOUR;
				acc_pkg::STEP_MIN:  out_step_q <= acc_pkg::STEP_CODE_MIN;
				default:            out_step_q <= acc_pkg::STEP_CODE_IDLE;
			endcase
			out_sh_q    <= shown_h_d;
			out_sm_q    <= shown_m_d;
			out_en_q    <= alm_en_d;
			out_ah_q    <= alm_h_d;
			out_am_q    <= alm_m_d;
			out_ring_q  <= ring_d;
			out_sound_q <= sound_d;
		end
	end

	// hour / 60 and minute / 12 by reciprocal multiply
	assign hour_prod = {11'd0, out_sh_q} * {10'd0, acc_pkg::RECIP_60};
	assign min_prod  = {13'd0, out_sm_q} * {10'd0, acc_pkg::RECIP_12};

	always_comb begin
		res.mode     = out_mode_q;
		res.step     = out_step_q;
		res.shown_h  = out_sh_q;
		res.shown_m  = out_sm_q;
		res.disp_h   = (hour_prod[19:16] == 4'd0) ? acc_pkg::NOON_HOUR : hour_prod[19:16];
		res.disp_m   = min_prod[21:16];
		res.alarm_on = out_en_q;
		res.alarm_h  = out_ah_q;
		res.alarm_m  = out_am_q;
		res.ringing  = out_ring_q;
		res.sound    = out_sound_q;
	end

`include "alarm_clock_controller_unit_assert.svh"

	`ACC_ASSERT_IMPL(a_sound_needs_ring, sound_q, ring_q, "sound on without ringing")
	`ACC_ASSERT_IMPL(a_ring_needs_alarm, ring_q, alm_en_q, "ringing with alarm disabled")
	`ACC_ASSERT_ALWAYS(a_mode_step_agree,
		(mode_q == acc_pkg::MODE_AMB) == (step_q == acc_pkg::STEP_IDLE),
		"mode and set step disagree")

endmodule

### hdl/alarm_clock_controller_unit.sv
// alarm clock controller top level: front end, command queue and back end
// an accepted beat waits in the command queue, then its result is registered in the back end
// throughput: one beat per cycle while m_tready keeps the back end's output register free
// the command queue of FIFO_DEPTH entries lets input and output stall independently
// reset: arst_n clears all clock, alarm and setting state; ticks per minute returns to 60
// reset: queued beats are dropped and none are invented, the output register comes up empty
module alarm_clock_controller_unit #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: ticks per minute
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	// input beats
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // btn_set_time, btn_set_alarm, btn_increment,
	                               // btn_decrement, btn_ambient, 3 bits zero
	input  logic        s_tuser,   // op: 0 tick, 1 button poll
	// result beats
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // mode, set_step, shown_hour_index, shown_minute_index,
	                               // display_hour, display_minute, alarm_on,
	                               // alarm_hour_index, alarm_minute_index, ringing,
	                               // sound_enable, 7 bits zero
);

	acc_pkg::cmd_t wr_cmd;
	acc_pkg::cmd_t rd_cmd;
	acc_pkg::res_t res;
	logic          push;
	logic          pop;
	logic          q_full;
	logic          q_not_empty;

	// button edge detection and classification
	acc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.push     (push),
		.cmd      (wr_cmd)
	);

	// decouples acceptance from execution
	acc_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_cmd    (wr_cmd),
		.pop       (pop),
		.rd_cmd    (rd_cmd),
		.full      (q_full),
		.not_empty (q_not_empty)
	);

	// state update; pops only when the output register can take the result
	acc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd_valid (q_not_empty),
		.cmd       (rd_cmd),
		.pop       (pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// pack result fields, first field in the low bits
	assign m_tdata = {7'd0, res};

endmodule
